FILE: rtl/rcat_pkg.sv
// Shared constants, request codes and control structs for the range count block.
`timescale 1ns / 1ps
`default_nettype none
package rcat_pkg;

	localparam int DEPTH_DEF = 1024;

	localparam int POS_W = 10;
	localparam int VAL_W = 32;
	localparam int CNT_W = 11;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic clr_wr;
		logic wr;
		logic q_load;
		logic rd;
		logic acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic q_empty;
		logic scan_last;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/rcat_if.sv
// Request and result channel interfaces of the range count block.
`timescale 1ns / 1ps
`default_nettype none
interface rcat_req_if;
	logic                               valid;
	logic                               ready;
	logic                               op;
	logic [rcat_pkg::POS_W-1:0]         position;
	logic signed [rcat_pkg::VAL_W-1:0]  value;
	logic [rcat_pkg::POS_W-1:0]         range_start;
	logic [rcat_pkg::POS_W-1:0]         range_end;
	logic signed [rcat_pkg::VAL_W-1:0]  threshold;

	modport source (output valid, op, position, value, range_start, range_end, threshold,
		input ready);
	modport sink (input valid, op, position, value, range_start, range_end, threshold,
		output ready);
endinterface

interface rcat_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rcat_pkg::CNT_W-1:0]  count;

	modport source (output valid, count, input ready);
	modport sink (input valid, count, output ready);
endinterface
`default_nettype wire

FILE: rtl/rcat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rcat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/rcat_ctrl.sv
// Controller state machine: clearing pass, request intake, range scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module rcat_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire rcat_pkg::sts_t sts,
	output rcat_pkg::cmd_t      cmd
);
	import rcat_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rd_s1;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.q_load = 1'b1;
						state_d = sts.q_empty ? ST_DONE : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.acc = rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= cmd.rd;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

FILE: rtl/rcat_dp.sv
// Datapath: element memory, clear and scan address counters, compare and count.
`timescale 1ns / 1ps
`default_nettype none
module rcat_dp #(
	parameter int DEPTH = rcat_pkg::DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rcat_pkg::cmd_t                    cmd,
	output rcat_pkg::sts_t                         sts,
	input  wire logic [rcat_pkg::POS_W-1:0]        position,
	input  wire logic signed [rcat_pkg::VAL_W-1:0] value,
	input  wire logic [rcat_pkg::POS_W-1:0]        range_start,
	input  wire logic [rcat_pkg::POS_W-1:0]        range_end,
	input  wire logic signed [rcat_pkg::VAL_W-1:0] threshold,
	output logic [rcat_pkg::CNT_W-1:0]             count
);
	import rcat_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [31:0] DEPTH_W = 32'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [AW-1:0]           clr_idx_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           end_q;
	logic signed [VAL_W-1:0] thr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        count_q;

	logic                    pos_ok;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic [VAL_W-1:0]        wdata;
	logic [VAL_W-1:0]        rdata;
	logic [AW-1:0]           end_clamp;

	assign pos_ok    = 32'(position) < DEPTH_W;
	assign we        = cmd.clr_wr || (cmd.wr && pos_ok);
	assign waddr     = cmd.clr_wr ? clr_idx_q : AW'(position);
	assign wdata     = cmd.clr_wr ? '0 : value;
	assign end_clamp = (32'(range_end) >= DEPTH_W) ? LAST_IDX : AW'(range_end);

	assign sts.clr_last  = clr_idx_q == LAST_IDX;
	assign sts.q_empty   = (range_start > range_end) || (32'(range_start) >= DEPTH_W);
	assign sts.scan_last = idx_q == end_q;

	rcat_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			idx_q <= AW'(range_start);
			end_q <= end_clamp;
			thr_q <= threshold;
		end else if (cmd.rd) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.q_load) begin
			cnt_q <= '0;
		end else if (cmd.acc && ($signed(rdata) <= thr_q)) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.out_load) begin
			count_q <= cnt_q;
		end
	end

	assign count = count_q;
endmodule
`default_nettype wire

FILE: rtl/range_count_at_most_threshold.sv
// Top level of the range count block: controller, datapath and channel hookup.
//
// The block stores DEPTH signed 32-bit elements in one RAM. Requests arrive on
// the req channel: a write request stores value at position (positions at or
// beyond DEPTH are dropped) and gives no result. A query request scans the
// positions from range_start to range_end, with range_end clamped to DEPTH-1,
// and returns on the rsp channel the number of elements less than or equal
// to threshold. An empty range returns a count of zero.
// A write is stored when it is accepted. A query scans with one RAM read per
// cycle and then loads its count into the output register; an empty range
// skips the scan. No new request is accepted while a query is in progress.
// After arst_n is released, the block runs a clearing pass that writes zero
// to every element, with req.ready low throughout.
// The result sits in an output register; a new request is accepted while
// it waits, and a following query holds its count until the receiver takes
// the previous one.
`timescale 1ns / 1ps
`default_nettype none
module range_count_at_most_threshold #(
	parameter int DEPTH = rcat_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rcat_req_if.sink   req,
	rcat_rsp_if.source rsp
);
	import rcat_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rcat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.op),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rcat_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.position   (req.position),
		.value      (req.value),
		.range_start(req.range_start),
		.range_end  (req.range_end),
		.threshold  (req.threshold),
		.count      (rsp.count)
	);
endmodule
`default_nettype wire
